// ===== design/mfvn_pkg.sv =====
package mfvn_pkg;

	localparam int DEF_MAX_VERTICES = 1024;
	localparam int DEF_COORD_BITS = 16;
	localparam int SUM_W = 26;
	localparam int QDEPTH = 2;
	localparam int QAW = $clog2(QDEPTH);

	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_FACE = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;
	localparam logic [1:0] KIND_NONE = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [9:0] vertex_index;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [15:0] pos_z;
		logic [9:0] corner_a;
		logic [9:0] corner_b;
		logic [9:0] corner_c;
	} req_t;

	typedef struct packed {
		logic valid;
		req_t req;
	} head_t;

	typedef struct packed {
		logic pop;
		logic ready;
	} back_st_t;

	typedef struct packed {
		logic done;
		logic degen;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} norm_res_t;

	typedef enum logic [3:0] {
		B_CLEAR,
		B_IDLE,
		B_WRITE,
		B_POS_RD,
		B_POS_LAT,
		B_MUL,
		B_NORM_GO,
		B_NORM_WAIT,
		B_ACC_RD,
		B_ACC_WR,
		B_SUM_RD,
		B_SUM_LAT,
		B_OUT
	} back_state_t;

	typedef enum logic [2:0] {
		N_IDLE,
		N_SHIFT,
		N_SQ,
		N_ROOT,
		N_DLOAD,
		N_DIV,
		N_DONE
	} norm_state_t;

endpackage

// ===== design/mfvn_ram.sv =====
module mfvn_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/mfvn_front.sv =====
module mfvn_front (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input logic [1:0] kind,
	input logic [9:0] vertex_index,
	input logic [15:0] pos_x,
	input logic [15:0] pos_y,
	input logic [15:0] pos_z,
	input logic [9:0] corner_a,
	input logic [9:0] corner_b,
	input logic [9:0] corner_c,
	input mfvn_pkg::back_st_t bst,
	output mfvn_pkg::head_t head
);

	import mfvn_pkg::*;

	req_t q_mem_q [QDEPTH];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QAW:0] cnt_q;
	logic full, push, pop;
	req_t in_req;

	assign in_req = '{kind: kind, vertex_index: vertex_index, pos_x: pos_x, pos_y: pos_y,
		pos_z: pos_z, corner_a: corner_a, corner_b: corner_b, corner_c: corner_c};

	assign full = (cnt_q == (QAW+1)'(QDEPTH));
	assign item_stall = full || !bst.ready;
	// Requests of the unused kind are taken and dropped here.
	assign push = item_valid && !item_stall && (kind != KIND_NONE);
	assign pop = bst.pop && head.valid;

	assign head.valid = (cnt_q != '0);
	assign head.req = q_mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wp_q] <= in_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/mfvn_norm.sv =====
module mfvn_norm #(
	parameter int NW = 35
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [NW-1:0] vec_x,
	input logic signed [NW-1:0] vec_y,
	input logic signed [NW-1:0] vec_z,
	output mfvn_pkg::norm_res_t res
);

	import mfvn_pkg::*;

	localparam int MW = (NW > 31) ? NW : 31;
	localparam int RW = 64;
	localparam int DW = 46;

	norm_state_t state_q, state_d;
	logic [MW-1:0] mag_q [3];
	logic sgn_q [3];
	logic [RW-1:0] x_q, r_q, bit_q;
	logic [59:0] sq_q;
	logic [1:0] cnt_q;
	logic [3:0] dcnt_q;
	logic [DW-1:0] rem_q, den_q;
	logic [14:0] qt_q;
	logic signed [15:0] out_q [3];
	logic degen_q;

	logic [MW-1:0] m01, mx;
	logic big, tiny, ge;
	logic [RW-1:0] t;
	logic [14:0] qn;
	logic signed [15:0] qs;

	function automatic logic [MW-1:0] mag_of(input logic signed [NW-1:0] v);
		logic [NW-1:0] a;
		a = v[NW-1] ? NW'(-v) : NW'(v);
		return MW'(a);
	endfunction

	assign m01 = (mag_q[0] > mag_q[1]) ? mag_q[0] : mag_q[1];
	assign mx = (m01 > mag_q[2]) ? m01 : mag_q[2];
	assign big = |mx[MW-1:30];
	assign tiny = ~|mx[MW-1:29];
	assign t = r_q + bit_q;
	assign ge = (rem_q >= den_q);
	assign qn = {qt_q[13:0], ge};
	assign qs = sgn_q[0] ? -signed'({1'b0, qn}) : signed'({1'b0, qn});

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			N_IDLE: begin
				if (start) begin
					state_d = (vec_x == '0 && vec_y == '0 && vec_z == '0) ? N_DONE : N_SHIFT;
				end
			end
			N_SHIFT: begin
				if (!big && !tiny) begin
					state_d = N_SQ;
				end
			end
			N_SQ: begin
				if (cnt_q == 2'd3) begin
					state_d = N_ROOT;
				end
			end
			N_ROOT: begin
				if (bit_q[0]) begin
					state_d = N_DLOAD;
				end
			end
			N_DLOAD: state_d = N_DIV;
			N_DIV: begin
				if (dcnt_q == 4'd14) begin
					state_d = (cnt_q == 2'd2) ? N_DONE : N_DLOAD;
				end
			end
			N_DONE: state_d = N_IDLE;
			default: state_d = N_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			N_IDLE: begin
				if (start) begin
					mag_q[0] <= mag_of(vec_x);
					mag_q[1] <= mag_of(vec_y);
					mag_q[2] <= mag_of(vec_z);
					sgn_q[0] <= vec_x[NW-1];
					sgn_q[1] <= vec_y[NW-1];
					sgn_q[2] <= vec_z[NW-1];
					out_q[0] <= '0;
					out_q[1] <= '0;
					out_q[2] <= '0;
					degen_q <= (vec_x == '0 && vec_y == '0 && vec_z == '0);
					cnt_q <= '0;
					x_q <= '0;
				end
			end
			N_SHIFT: begin
				if (big) begin
					mag_q[0] <= mag_q[0] >> 1;
					mag_q[1] <= mag_q[1] >> 1;
					mag_q[2] <= mag_q[2] >> 1;
				end else if (tiny) begin
					mag_q[0] <= mag_q[0] << 1;
					mag_q[1] <= mag_q[1] << 1;
					mag_q[2] <= mag_q[2] << 1;
				end
			end
			N_SQ: begin
				if (cnt_q != 2'd3) begin
					sq_q <= mag_q[0][29:0] * mag_q[0][29:0];
					mag_q[0] <= mag_q[1];
					mag_q[1] <= mag_q[2];
					mag_q[2] <= mag_q[0];
					sgn_q[0] <= sgn_q[1];
					sgn_q[1] <= sgn_q[2];
					sgn_q[2] <= sgn_q[0];
				end
				if (cnt_q != 2'd0) begin
					x_q <= x_q + RW'(sq_q);
				end
				cnt_q <= cnt_q + 1'b1;
				r_q <= '0;
				bit_q <= RW'(1) << 62;
			end
			N_ROOT: begin
				if (x_q >= t) begin
					x_q <= x_q - t;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
				cnt_q <= '0;
			end
			N_DLOAD: begin
				rem_q <= {2'b00, mag_q[0][29:0], 14'b0} + DW'(r_q[31:1]);
				den_q <= {r_q[31:0], 14'b0};
				qt_q <= '0;
				dcnt_q <= '0;
			end
			N_DIV: begin
				if (ge) begin
					rem_q <= rem_q - den_q;
				end
				qt_q <= qn;
				den_q <= den_q >> 1;
				dcnt_q <= dcnt_q + 1'b1;
				if (dcnt_q == 4'd14) begin
					out_q[2] <= qs;
					out_q[1] <= out_q[2];
					out_q[0] <= out_q[1];
					mag_q[0] <= mag_q[1];
					mag_q[1] <= mag_q[2];
					mag_q[2] <= mag_q[0];
					sgn_q[0] <= sgn_q[1];
					sgn_q[1] <= sgn_q[2];
					sgn_q[2] <= sgn_q[0];
					cnt_q <= cnt_q + 1'b1;
				end
			end
			N_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign res.done = (state_q == N_DONE);
	assign res.degen = degen_q;
	assign res.x = out_q[0];
	assign res.y = out_q[1];
	assign res.z = out_q[2];

endmodule

// ===== design/mfvn_back.sv =====
module mfvn_back #(
	parameter int MAX_VERTICES = mfvn_pkg::DEF_MAX_VERTICES,
	parameter int COORD_BITS = mfvn_pkg::DEF_COORD_BITS
) (
	input logic clk,
	input logic arst_n,
	input mfvn_pkg::head_t head,
	output mfvn_pkg::back_st_t bst,
	output logic result_valid,
	input logic result_stall,
	output logic [1:0] result_kind,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic degenerate
);

	import mfvn_pkg::*;

	localparam int CW = COORD_BITS;
	localparam int AW = $clog2(MAX_VERTICES);
	localparam int EW = CW + 1;
	localparam int PW = 2 * EW;
	localparam int XW = PW + 1;
	localparam int NW = (XW > SUM_W) ? XW : SUM_W;
	localparam int PSW = 3 * CW;
	localparam int ASW = 3 * SUM_W;

	back_state_t state_q, state_d;
	req_t cur_q;
	logic [AW-1:0] clr_q;
	logic [1:0] cnt_q;
	logic [2:0] mcnt_q;
	logic prev_ok_q;
	logic signed [CW-1:0] pa_q [3];
	logic signed [EW-1:0] e1_q [3];
	logic signed [EW-1:0] e2_q [3];
	logic signed [PW-1:0] prod_q;
	logic signed [NW-1:0] vec_q [3];
	logic res_valid_q, res_degen_q;
	logic [1:0] res_kind_q;
	logic signed [15:0] res_x_q, res_y_q, res_z_q;

	logic pos_we, sum_we, norm_start, out_load;
	logic [AW-1:0] pos_waddr, pos_raddr, sum_waddr, sum_raddr;
	logic [PSW-1:0] pos_wdata, pos_rdata;
	logic [ASW-1:0] sum_wdata, sum_rdata, acc_new;
	logic [9:0] csel;
	logic signed [CW-1:0] rd_p [3];
	logic signed [SUM_W-1:0] rd_s [3];
	logic signed [EW-1:0] op_a, op_b;
	norm_res_t nres;

	function automatic logic signed [CW-1:0] coord_of(input logic [15:0] raw);
		logic [CW+23:0] w;
		w = {24'b0, raw};
		return w[CW-1:0];
	endfunction

	function automatic logic in_range(input logic [9:0] idx);
		return 32'(idx) < 32'(MAX_VERTICES);
	endfunction

	function automatic logic [AW-1:0] addr_of(input logic [9:0] idx);
		logic [AW+9:0] w;
		w = {{AW{1'b0}}, idx};
		return w[AW-1:0];
	endfunction

	function automatic logic [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] s,
			input logic signed [15:0] d);
		logic signed [SUM_W:0] w;
		w = (SUM_W+1)'(s) + (SUM_W+1)'(d);
		if (w[SUM_W] != w[SUM_W-1]) begin
			return w[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end
		return w[SUM_W-1:0];
	endfunction

	assign rd_p[0] = pos_rdata[PSW-1 -: CW];
	assign rd_p[1] = pos_rdata[2*CW-1 -: CW];
	assign rd_p[2] = pos_rdata[CW-1:0];
	assign rd_s[0] = sum_rdata[ASW-1 -: SUM_W];
	assign rd_s[1] = sum_rdata[2*SUM_W-1 -: SUM_W];
	assign rd_s[2] = sum_rdata[SUM_W-1:0];
	assign acc_new = {sat_add(rd_s[0], nres.x), sat_add(rd_s[1], nres.y),
		sat_add(rd_s[2], nres.z)};

	always_comb begin
		unique case (cnt_q)
			2'd0: csel = cur_q.corner_a;
			2'd1: csel = cur_q.corner_b;
			default: csel = cur_q.corner_c;
		endcase
	end

	always_comb begin
		unique case (mcnt_q)
			3'd0: begin op_a = e1_q[1]; op_b = e2_q[2]; end
			3'd1: begin op_a = e1_q[2]; op_b = e2_q[1]; end
			3'd2: begin op_a = e1_q[2]; op_b = e2_q[0]; end
			3'd3: begin op_a = e1_q[0]; op_b = e2_q[2]; end
			3'd4: begin op_a = e1_q[0]; op_b = e2_q[1]; end
			default: begin op_a = e1_q[1]; op_b = e2_q[0]; end
		endcase
	end

	always_comb begin
		state_d = state_q;
		pos_we = 1'b0;
		pos_waddr = addr_of(cur_q.vertex_index);
		pos_wdata = {coord_of(cur_q.pos_x), coord_of(cur_q.pos_y), coord_of(cur_q.pos_z)};
		pos_raddr = addr_of(csel);
		sum_we = 1'b0;
		sum_waddr = addr_of(csel);
		sum_wdata = acc_new;
		sum_raddr = addr_of(csel);
		bst.pop = 1'b0;
		bst.ready = (state_q != B_CLEAR);
		norm_start = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			B_CLEAR: begin
				sum_we = 1'b1;
				sum_waddr = clr_q;
				sum_wdata = '0;
				if (clr_q == AW'(MAX_VERTICES - 1)) begin
					state_d = B_IDLE;
				end
			end
			B_IDLE: begin
				if (head.valid) begin
					bst.pop = 1'b1;
					unique case (head.req.kind)
						KIND_WRITE: state_d = B_WRITE;
						KIND_FACE: state_d = B_POS_RD;
						KIND_READ: state_d = B_SUM_RD;
						default: state_d = B_IDLE;
					endcase
				end
			end
			B_WRITE: begin
				if (in_range(cur_q.vertex_index)) begin
					pos_we = 1'b1;
					sum_we = 1'b1;
					sum_waddr = addr_of(cur_q.vertex_index);
					sum_wdata = '0;
				end
				state_d = B_OUT;
			end
			B_POS_RD: begin
				if (cnt_q == 2'd2) begin
					state_d = B_POS_LAT;
				end
			end
			B_POS_LAT: state_d = B_MUL;
			B_MUL: begin
				if (mcnt_q == 3'd6) begin
					state_d = B_NORM_GO;
				end
			end
			B_NORM_GO: begin
				norm_start = 1'b1;
				state_d = B_NORM_WAIT;
			end
			B_NORM_WAIT: begin
				if (nres.done) begin
					state_d = (cur_q.kind == KIND_FACE) ? B_ACC_RD : B_OUT;
				end
			end
			B_ACC_RD: begin
				if (in_range(csel)) begin
					state_d = B_ACC_WR;
				end else if (cnt_q == 2'd2) begin
					state_d = B_OUT;
				end
			end
			B_ACC_WR: begin
				sum_we = 1'b1;
				state_d = (cnt_q == 2'd2) ? B_OUT : B_ACC_RD;
			end
			B_SUM_RD: begin
				sum_raddr = addr_of(cur_q.vertex_index);
				state_d = B_SUM_LAT;
			end
			B_SUM_LAT: state_d = B_NORM_GO;
			B_OUT: begin
				if (!res_valid_q || !result_stall) begin
					out_load = 1'b1;
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
			clr_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bst.pop) begin
			cur_q <= head.req;
		end
		prev_ok_q <= in_range(csel);
		unique case (state_q)
			B_IDLE: begin
				cnt_q <= '0;
				mcnt_q <= '0;
			end
			B_POS_RD: begin
				if (cnt_q == 2'd1) begin
					for (int i = 0; i < 3; i++) begin
						pa_q[i] <= prev_ok_q ? rd_p[i] : '0;
					end
				end else if (cnt_q == 2'd2) begin
					for (int i = 0; i < 3; i++) begin
						e1_q[i] <= EW'(prev_ok_q ? rd_p[i] : CW'(0)) - EW'(pa_q[i]);
					end
				end
				cnt_q <= cnt_q + 1'b1;
			end
			B_POS_LAT: begin
				for (int i = 0; i < 3; i++) begin
					e2_q[i] <= EW'(prev_ok_q ? rd_p[i] : CW'(0)) - EW'(pa_q[i]);
				end
			end
			B_MUL: begin
				prod_q <= op_a * op_b;
				mcnt_q <= mcnt_q + 1'b1;
				unique case (mcnt_q)
					3'd1: vec_q[0] <= NW'(prod_q);
					3'd2: vec_q[0] <= vec_q[0] - NW'(prod_q);
					3'd3: vec_q[1] <= NW'(prod_q);
					3'd4: vec_q[1] <= vec_q[1] - NW'(prod_q);
					3'd5: vec_q[2] <= NW'(prod_q);
					3'd6: vec_q[2] <= vec_q[2] - NW'(prod_q);
					default: begin
					end
				endcase
			end
			B_NORM_WAIT: cnt_q <= '0;
			B_ACC_RD: begin
				if (!in_range(csel) && cnt_q != 2'd2) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			B_ACC_WR: cnt_q <= cnt_q + 1'b1;
			B_SUM_LAT: begin
				for (int i = 0; i < 3; i++) begin
					vec_q[i] <= in_range(cur_q.vertex_index) ? NW'(rd_s[i]) : '0;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			res_kind_q <= cur_q.kind;
			res_x_q <= (cur_q.kind == KIND_WRITE) ? '0 : nres.x;
			res_y_q <= (cur_q.kind == KIND_WRITE) ? '0 : nres.y;
			res_z_q <= (cur_q.kind == KIND_WRITE) ? '0 : nres.z;
			res_degen_q <= (cur_q.kind == KIND_WRITE) ? 1'b0 : nres.degen;
		end
	end

	mfvn_ram #(
		.WIDTH(PSW),
		.DEPTH(MAX_VERTICES)
	) u_pos_ram (
		.clk(clk),
		.we(pos_we),
		.waddr(pos_waddr),
		.wdata(pos_wdata),
		.raddr(pos_raddr),
		.rdata(pos_rdata)
	);

	mfvn_ram #(
		.WIDTH(ASW),
		.DEPTH(MAX_VERTICES)
	) u_sum_ram (
		.clk(clk),
		.we(sum_we),
		.waddr(sum_waddr),
		.wdata(sum_wdata),
		.raddr(sum_raddr),
		.rdata(sum_rdata)
	);

	mfvn_norm #(
		.NW(NW)
	) u_norm (
		.clk(clk),
		.arst_n(arst_n),
		.start(norm_start),
		.vec_x(vec_q[0]),
		.vec_y(vec_q[1]),
		.vec_z(vec_q[2]),
		.res(nres)
	);

	assign result_valid = res_valid_q;
	assign result_kind = res_kind_q;
	assign normal_x = res_x_q;
	assign normal_y = res_y_q;
	assign normal_z = res_z_q;
	assign degenerate = res_degen_q;

	a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_CLEAR |-> !bst.pop)
		else $error("request taken during accumulator clearing");

	a_norm_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		nres.done |-> state_q == B_NORM_WAIT)
		else $error("normalizer finished while not awaited");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
		else $error("degenerate result with nonzero normal");

	a_write_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_kind == KIND_WRITE |-> !degenerate && normal_x == '0)
		else $error("vertex write result carries a normal");

endmodule

// ===== design/mesh_face_vertex_normals_core.sv =====
// One request is served at a time: the next one is not taken until the previous result
// is loaded into the output register, and a two-entry queue buffers the waiting requests.
// The normalizer does one shift per cycle, then squares the components, takes a 32-step
// root and does three divisions; a zero vector, from a degenerate face or a zero sum,
// goes straight to its result. After reset a clearing pass zeroes the accumulators and
// stalls requests; vertex positions are undefined until written.
module mesh_face_vertex_normals_core #(
	parameter int MAX_VERTICES = mfvn_pkg::DEF_MAX_VERTICES,
	parameter int COORD_BITS = mfvn_pkg::DEF_COORD_BITS
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input logic [1:0] kind,
	input logic [9:0] vertex_index,
	input logic signed [15:0] pos_x,
	input logic signed [15:0] pos_y,
	input logic signed [15:0] pos_z,
	input logic [9:0] corner_a,
	input logic [9:0] corner_b,
	input logic [9:0] corner_c,
	output logic result_valid,
	input logic result_stall,
	output logic [1:0] result_kind,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic degenerate
);

	import mfvn_pkg::*;

	head_t head;
	back_st_t bst;

	mfvn_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.kind(kind),
		.vertex_index(vertex_index),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z),
		.corner_a(corner_a),
		.corner_b(corner_b),
		.corner_c(corner_c),
		.bst(bst),
		.head(head)
	);

	mfvn_back #(
		.MAX_VERTICES(MAX_VERTICES),
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.bst(bst),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_kind(result_kind),
		.normal_x(normal_x),
		.normal_y(normal_y),
		.normal_z(normal_z),
		.degenerate(degenerate)
	);

endmodule
